// ===== sv/apc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apc_pkg: shared types and constants of the analog pot counter unit
// Item kinds, go-word bit masks, capacitor levels and the per-line control
// struct used between the top level and the pot line slices.
// ----------------------------------------------------------------------------
package apc_pkg;

	localparam int NUM_LINES = 4;

	// item kinds
	typedef enum logic [2:0] {
		KIND_TICK   = 3'd0,
		KIND_GO     = 3'd1,
		KIND_RD0    = 3'd2,
		KIND_RD1    = 3'd3,
		KIND_STATUS = 3'd4
	} apc_kind_t;

	// go-word direction (1 = output) and data bits, order X0, Y0, X1, Y1
	localparam logic [15:0] DIR_MASK [NUM_LINES] = '{16'h0200, 16'h0800, 16'h2000, 16'h8000};
	localparam logic [15:0] DAT_MASK [NUM_LINES] = '{16'h0100, 16'h0400, 16'h1000, 16'h4000};

	localparam logic [7:0] CAP_FULL   = 8'hff;
	localparam logic [7:0] CAP_EMPTY  = 8'h00;
	localparam logic [3:0] LINES_NTSC = 4'd7;
	localparam logic [3:0] LINES_PAL  = 4'd8;

	// per-line control for one accepted item
	typedef struct packed {
		logic load;       // force level from go word
		logic load_full;  // forced level is full, else empty
		logic drain;      // discharge tick empties the capacitor
		logic count;      // counting tick
		logic charge;     // line in input mode charges on a counting tick
		logic clr;        // start bit clears the counter
	} apc_line_ctl_t;

endpackage

// ===== sv/apc_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apc_in_if: input item channel
// Valid/ready handshake carrying one request item of the pot counter unit.
// ----------------------------------------------------------------------------
interface apc_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [15:0] write_data;
	logic [7:0]  rate_x0;
	logic [7:0]  rate_y0;
	logic [7:0]  rate_x1;
	logic [7:0]  rate_y1;

	modport source (
		output valid, kind, write_data, rate_x0, rate_y0, rate_x1, rate_y1,
		input  ready
	);

	modport sink (
		input  valid, kind, write_data, rate_x0, rate_y0, rate_x1, rate_y1,
		output ready
	);
endinterface

// ===== sv/apc_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apc_out_if: result item channel
// Valid/ready handshake carrying one result item of the pot counter unit.
// ----------------------------------------------------------------------------
interface apc_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] read_data;
	logic        busy_res;

	modport source (
		output valid, read_data, busy_res,
		input  ready
	);

	modport sink (
		input  valid, read_data, busy_res,
		output ready
	);
endinterface

// ===== sv/apc_line.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apc_line: one pot line slice
// Holds the 8-bit counter and 8-bit capacitor level of one line and applies
// the force, discharge, count and charge updates of one item.
// ----------------------------------------------------------------------------
module apc_line (
	input  logic                  clk,
	input  logic                  arst_n,
	input  apc_pkg::apc_line_ctl_t ctl,
	input  logic [7:0]            rate,
	output logic [7:0]            count,
	output logic                  not_full,
	output logic                  full_next
);
	import apc_pkg::*;

	logic [7:0] cnt_q;
	logic [7:0] cap_q;
	logic [7:0] cnt_d;
	logic [7:0] cap_d;
	logic [8:0] sum;

	// saturating charge
	assign sum = {1'b0, cap_q} + {1'b0, rate};

	// next counter and level
	always_comb begin
		cnt_d = cnt_q;
		cap_d = cap_q;
		if (ctl.load) begin
			cap_d = ctl.load_full ? CAP_FULL : CAP_EMPTY;
		end
		if (ctl.drain) begin
			cap_d = CAP_EMPTY;
		end
		if (ctl.clr) begin
			cnt_d = 8'd0;
		end
		if (ctl.count && (cap_q != CAP_FULL)) begin
			cnt_d = cnt_q + 8'd1;
			if (ctl.charge) begin
				cap_d = sum[8] ? CAP_FULL : sum[7:0];
			end
		end
	end

	// state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 8'd0;
			cap_q <= CAP_EMPTY;
		end else begin
			cnt_q <= cnt_d;
			cap_q <= cap_d;
		end
	end

	assign count     = cnt_q;
	assign not_full  = (cap_q != CAP_FULL);
	assign full_next = (cap_d == CAP_FULL);

endmodule

// ===== sv/apc_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apc_out_stage: result register
// Holds one finished result item; takes a new one whenever it is empty or
// its item leaves in the same cycle.
// ----------------------------------------------------------------------------
module apc_out_stage (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  logic [15:0]  read_data,
	input  logic         busy_res,
	output logic         can_load,
	apc_out_if.source    rsp
);
	logic        valid_q;
	logic [15:0] read_data_q;
	logic        busy_q;

	assign can_load = !valid_q || rsp.ready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load && can_load) begin
			read_data_q <= read_data;
			busy_q      <= busy_res;
		end
	end

	assign rsp.valid     = valid_q;
	assign rsp.read_data = read_data_q;
	assign rsp.busy_res  = busy_q;

endmodule

// ===== sv/analog_pot_counter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// analog_pot_counter_unit: four-line paddle pot counter
// Top level: go-word and discharge control, four line slices, result stage.
// ----------------------------------------------------------------------------
// Each request item (scanline tick, go-word write, port read or go status
// read) updates the pot line state and the result register at the same
// edge, the edge that accepts the item. A new item can be accepted every
// cycle, including while a finished result waits, as long as the result
// register is empty or being emptied; the only stall comes from the result
// side. Every item gives exactly one result: read_data carries the counter
// pair or the full-line bits (zero for ticks and writes) and busy_res the
// measurement-running flag after the item. cfg_wdata selects NTSC (7
// discharge lines) when 1, PAL (8) when 0, and must be written only while
// the block is idle; the block itself does not enforce this.
module analog_pot_counter_unit (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_we,
	input  logic     cfg_wdata,
	apc_in_if.sink   req,
	apc_out_if.source rsp
);
	import apc_pkg::*;

	logic        ntsc_q;
	logic [15:0] go_q;
	logic [3:0]  left_q;
	logic        running_q;

	logic        accept;
	logic        can_load;
	apc_kind_t   kind;
	logic [15:0] apply_word;
	logic        apply_en;
	logic        tick_dis;
	logic        tick_cnt;
	logic [3:0]  left_dec;
	logic        start;

	logic [15:0] go_d;
	logic [3:0]  left_d;
	logic        running_d;
	logic [15:0] rd;

	apc_line_ctl_t ctl       [NUM_LINES];
	logic [7:0]    rate      [NUM_LINES];
	logic [7:0]    count     [NUM_LINES];
	logic          not_full  [NUM_LINES];
	logic          full_next [NUM_LINES];

	// handshake and item decode
	assign req.ready  = can_load;
	assign accept     = req.valid && can_load;
	assign kind       = apc_kind_t'(req.kind);
	assign apply_word = (kind == KIND_GO) ? req.write_data : go_q;
	assign apply_en   = accept && ((kind == KIND_GO) || (kind == KIND_RD0) ||
	                               (kind == KIND_RD1) || (kind == KIND_STATUS));
	assign tick_dis   = accept && (kind == KIND_TICK) && (left_q != 4'd0);
	assign tick_cnt   = accept && (kind == KIND_TICK) && (left_q == 4'd0);
	assign left_dec   = left_q - 4'd1;
	assign start      = accept && (kind == KIND_GO) && req.write_data[0];

	assign rate[0] = req.rate_x0;
	assign rate[1] = req.rate_y0;
	assign rate[2] = req.rate_x1;
	assign rate[3] = req.rate_y1;

	// pot line slices
	for (genvar i = 0; i < NUM_LINES; i++) begin : g_line
		always_comb begin
			ctl[i].load      = apply_en && ((apply_word & DIR_MASK[i]) != 16'd0);
			ctl[i].load_full = (apply_word & DAT_MASK[i]) != 16'd0;
			ctl[i].drain     = tick_dis && (left_dec != 4'd0) &&
			                   ((go_q & DIR_MASK[i]) == 16'd0);
			ctl[i].count     = tick_cnt;
			ctl[i].charge    = (go_q & DIR_MASK[i]) == 16'd0;
			ctl[i].clr       = start;
		end

		apc_line u_line (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl[i]),
			.rate      (rate[i]),
			.count     (count[i]),
			.not_full  (not_full[i]),
			.full_next (full_next[i])
		);
	end

	// control state and result data
	always_comb begin
		go_d      = go_q;
		left_d    = left_q;
		running_d = running_q;
		rd        = 16'd0;
		unique case (kind)
			KIND_TICK: begin
				if (left_q != 4'd0) begin
					left_d = left_dec;
				end else begin
					running_d = not_full[0] || not_full[1] || not_full[2] || not_full[3];
				end
			end
			KIND_GO: begin
				go_d = req.write_data;
				if (req.write_data[0]) begin
					left_d    = ntsc_q ? LINES_NTSC : LINES_PAL;
					running_d = 1'b1;
				end
			end
			KIND_RD0: begin
				running_d = 1'b1;
				rd        = {count[1], count[0]};
			end
			KIND_RD1: begin
				running_d = 1'b1;
				rd        = {count[3], count[2]};
			end
			KIND_STATUS: begin
				for (int i = 0; i < NUM_LINES; i++) begin
					if (full_next[i]) begin
						rd = rd | DAT_MASK[i];
					end
				end
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ntsc_q    <= 1'b0;
			go_q      <= 16'd0;
			left_q    <= 4'd0;
			running_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				ntsc_q <= cfg_wdata;
			end
			if (accept) begin
				go_q      <= go_d;
				left_q    <= left_d;
				running_q <= running_d;
			end
		end
	end

	// result register
	apc_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.read_data (rd),
		.busy_res  (running_d),
		.can_load  (can_load),
		.rsp       (rsp)
	);

	// every accepted item shows up as a result on the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> rsp.valid)
		else $error("accepted item produced no result");

	// discharge never exceeds the longest line count
	a_left_range: assert property (@(posedge clk) disable iff (!arst_n)
		left_q <= LINES_PAL)
		else $error("discharge count out of range");

	// a measurement in discharge is always running
	a_discharge_busy: assert property (@(posedge clk) disable iff (!arst_n)
		left_q != 4'd0 |-> running_q)
		else $error("discharge without running flag");

	// a start write loads the discharge count and shows busy
	a_start_loads: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (left_q == LINES_NTSC || left_q == LINES_PAL) && running_q && rsp.busy_res)
		else $error("start write did not begin a measurement");

endmodule
